>>> hw/rtl/hsv_colour_adjust_top_defines.svh
// Assertion macros shared by the colour adjustment block.
`ifndef HSV_COLOUR_ADJUST_TOP_DEFINES_SVH
`define HSV_COLOUR_ADJUST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HSVCA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HSVCA_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSVCA_ASSERT(lbl, prop, msg)
`define HSVCA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/hsvca_pkg.sv
package hsvca_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CHAN_W        = 8;
	localparam int HUE_OFF_W     = 10;
	localparam int SAT_OFF_W     = 18;
	localparam int VAL_OFF_W     = 18;
	localparam int HUE_W         = 9;
	localparam int ADDR_W        = 4;
	localparam int DATA_W        = 32;

	typedef enum logic [1:0] {
		REG_HUE = 2'd0,
		REG_SAT = 2'd1,
		REG_VAL = 2'd2
	} reg_idx_t;

	// Special cases carried alongside the two divisions.
	typedef struct packed {
		logic zero_d;
		logic zero_mx;
	} div_flags_t;

endpackage

>>> hw/rtl/hsvca_if.sv
interface hsvca_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hsvca_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

>>> hw/rtl/hsvca_front.sv
module hsvca_front #(
	parameter int FRAC_BITS = hsvca_pkg::FRAC_BITS_DEF,
	parameter int NUM_W     = FRAC_BITS + 9,
	parameter int VAL_W     = FRAC_BITS + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              red,
	input  logic [7:0]              green,
	input  logic [7:0]              blue,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [NUM_W-1:0]        hnum,
	output logic [7:0]              hden,
	output logic [NUM_W-1:0]        snum,
	output logic [7:0]              sden,
	output logic [VAL_W-1:0]        val,
	output hsvca_pkg::div_flags_t   flags
);

	logic [VAL_W-1:0] val_tab [256];

	for (genvar i = 0; i < 256; i++) begin : g_vtab
		localparam longint unsigned VT = (longint'(i) << FRAC_BITS) / 255;
		assign val_tab[i] = VAL_W'(VT);
	end

	logic [7:0]         mx, mn, d;
	logic signed [9:0]  dgb, dbr, drg;
	logic signed [18:0] dd, hn;

	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		d = mx - mn;
		dgb = $signed({2'b0, green}) - $signed({2'b0, blue});
		dbr = $signed({2'b0, blue}) - $signed({2'b0, red});
		drg = $signed({2'b0, red}) - $signed({2'b0, green});
		dd = $signed({11'b0, d});
		// Ties go to red first, then green.
		if (mx == red) begin
			hn = 19'sd60 * 19'(dgb);
			if (hn < 0) hn = hn + 19'sd360 * dd;
		end else if (mx == green) begin
			hn = 19'sd60 * 19'(dbr) + 19'sd120 * dd;
		end else begin
			hn = 19'sd60 * 19'(drg) + 19'sd240 * dd;
		end
	end

	logic valid_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			hnum          <= NUM_W'(hn[16:0]);
			hden          <= d;
			snum          <= NUM_W'({d, {FRAC_BITS{1'b0}}});
			sden          <= mx;
			val           <= val_tab[mx];
			flags.zero_d  <= (d == 8'd0);
			flags.zero_mx <= (mx == 8'd0);
		end
	end

endmodule

>>> hw/rtl/hsvca_div.sv
// Two restoring dividers in lock step, one quotient bit per stage.
// The numerator must be below den * 2^Q_W.
module hsvca_div #(
	parameter int Q_W   = hsvca_pkg::FRAC_BITS_DEF + 1,
	parameter int SB_W  = 1,
	parameter int NUM_W = Q_W + 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NUM_W-1:0] num_a,
	input  logic [7:0]       den_a,
	input  logic [NUM_W-1:0] num_b,
	input  logic [7:0]       den_b,
	input  logic [SB_W-1:0]  sb_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Q_W-1:0]   quo_a,
	output logic [Q_W-1:0]   quo_b,
	output logic [SB_W-1:0]  sb_out
);

	logic             valid_s [Q_W];
	logic             rdy     [Q_W+1];
	logic [NUM_W-1:0] rem_a_s [Q_W-1];
	logic [NUM_W-1:0] rem_b_s [Q_W-1];
	logic [7:0]       den_a_s [Q_W];
	logic [7:0]       den_b_s [Q_W];
	logic [Q_W-1:0]   quo_a_s [Q_W];
	logic [Q_W-1:0]   quo_b_s [Q_W];
	logic [SB_W-1:0]  sb_s    [Q_W];

	assign rdy[Q_W]  = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = valid_s[Q_W-1];
	assign quo_a     = quo_a_s[Q_W-1];
	assign quo_b     = quo_b_s[Q_W-1];
	assign sb_out    = sb_s[Q_W-1];

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		localparam int J = Q_W - 1 - i;
		logic             v_in;
		logic [NUM_W-1:0] ra_in, rb_in, sa, sb, ra_nx, rb_nx;
		logic [7:0]       da_in, db_in;
		logic [Q_W-1:0]   qa_in, qb_in, qa_nx, qb_nx;
		logic [SB_W-1:0]  side_in;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign ra_in   = num_a;
			assign rb_in   = num_b;
			assign da_in   = den_a;
			assign db_in   = den_b;
			assign qa_in   = '0;
			assign qb_in   = '0;
			assign side_in = sb_in;
		end else begin : g_rest
			assign v_in    = valid_s[i-1];
			assign ra_in   = rem_a_s[i-1];
			assign rb_in   = rem_b_s[i-1];
			assign da_in   = den_a_s[i-1];
			assign db_in   = den_b_s[i-1];
			assign qa_in   = quo_a_s[i-1];
			assign qb_in   = quo_b_s[i-1];
			assign side_in = sb_s[i-1];
		end

		assign rdy[i] = !valid_s[i] || rdy[i+1];

		always_comb begin
			sa    = NUM_W'(da_in) << J;
			sb    = NUM_W'(db_in) << J;
			qa_nx = qa_in;
			qb_nx = qb_in;
			qa_nx[J] = (ra_in >= sa);
			qb_nx[J] = (rb_in >= sb);
			ra_nx = qa_nx[J] ? ra_in - sa : ra_in;
			rb_nx = qb_nx[J] ? rb_in - sb : rb_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i]) begin
				den_a_s[i] <= da_in;
				den_b_s[i] <= db_in;
				quo_a_s[i] <= qa_nx;
				quo_b_s[i] <= qb_nx;
				sb_s[i]    <= side_in;
			end
		end

		if (i < Q_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (rdy[i]) begin
					rem_a_s[i] <= ra_nx;
					rem_b_s[i] <= rb_nx;
				end
			end
		end else begin : g_norem
			// The final remainders are not needed.
			logic unused_rem;
			assign unused_rem = ^{ra_nx, rb_nx};
		end
	end

endmodule

>>> hw/rtl/hsvca_back.sv
// Offsets, clamping and the conversion back to RGB, five register stages.
module hsvca_back #(
	parameter int FRAC_BITS = hsvca_pkg::FRAC_BITS_DEF,
	parameter int VAL_W     = FRAC_BITS + 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [VAL_W-1:0]                     hue_q,
	input  logic [VAL_W-1:0]                     sat_q,
	input  logic [VAL_W-1:0]                     val,
	input  hsvca_pkg::div_flags_t                flags,
	input  logic signed [hsvca_pkg::HUE_OFF_W-1:0] hue_off,
	input  logic signed [hsvca_pkg::SAT_OFF_W-1:0] sat_off,
	input  logic signed [hsvca_pkg::VAL_OFF_W-1:0] val_off,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           red,
	output logic [7:0]                           green,
	output logic [7:0]                           blue
);

	localparam int NS    = 5;
	localparam int OW    = ((VAL_W > 18) ? VAL_W : 18) + 2;
	localparam int K     = FRAC_BITS + 12;
	localparam int RW    = FRAC_BITS + 7;
	localparam int XN_W  = VAL_W + 6;
	localparam int XP_W  = XN_W + RW;
	localparam longint unsigned RECIP = ((longint'(1) << K) + 59) / 60;
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
	localparam logic signed [OW-1:0] ONE_S = OW'(longint'(1) << FRAC_BITS);

	logic valid_s [NS];
	logic rdy     [NS+1];

	assign rdy[NS]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = valid_s[NS-1];

	for (genvar i = 0; i < NS; i++) begin : g_ctl
		assign rdy[i] = !valid_s[i] || rdy[i+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				valid_s[i] <= (i == 0) ? in_valid : valid_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	// Stage 1: add offsets, clamp, find sector and triangle weight.
	logic [8:0]             hue;
	logic signed [11:0]     hsum;
	logic signed [OW-1:0]   ssum, vsum;
	logic [8:0]             h2, k, tri_gap;
	logic [VAL_W-1:0]       s2, v2;
	logic [2:0]             sect;

	always_comb begin
		hue  = flags.zero_d ? 9'd0 : hue_q[8:0];
		hsum = $signed({3'b0, hue}) + 12'(hue_off);
		if (hsum < 0) h2 = 9'd0;
		else if (hsum > 12'sd360) h2 = 9'd360;
		else h2 = hsum[8:0];
		ssum = $signed(OW'({1'b0, (flags.zero_mx ? '0 : sat_q)})) + OW'(sat_off);
		vsum = $signed(OW'({1'b0, val})) + OW'(val_off);
		if (ssum < 0) s2 = '0;
		else if (ssum > ONE_S) s2 = VAL_W'(ONE_S);
		else s2 = ssum[VAL_W-1:0];
		if (vsum < 0) v2 = '0;
		else if (vsum > ONE_S) v2 = VAL_W'(ONE_S);
		else v2 = vsum[VAL_W-1:0];
		sect = 3'(h2 >= 9'd60) + 3'(h2 >= 9'd120) + 3'(h2 >= 9'd180)
			+ 3'(h2 >= 9'd240) + 3'(h2 >= 9'd300) + 3'(h2 >= 9'd360);
		if (h2 >= 9'd360) k = h2 - 9'd360;
		else if (h2 >= 9'd240) k = h2 - 9'd240;
		else if (h2 >= 9'd120) k = h2 - 9'd120;
		else k = h2;
		tri_gap = (k >= 9'd60) ? k - 9'd60 : 9'd60 - k;
	end

	logic [VAL_W-1:0] s_s1, v_s1;
	logic [5:0]       w_s1;
	logic [2:0]       sect_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			s_s1    <= s2;
			v_s1    <= v2;
			w_s1    <= 6'(9'd60 - tri_gap);
			// Full circle falls in the last sector.
			sect_s1 <= (sect == 3'd6) ? 3'd5 : sect;
		end
	end

	// Stage 2: chroma.
	logic [2*VAL_W-1:0] cprod;
	logic [VAL_W-1:0]   c_s2, v_s2;
	logic [5:0]         w_s2;
	logic [2:0]         sect_s2;

	assign cprod = v_s1 * s_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			c_s2    <= cprod[FRAC_BITS +: VAL_W];
			v_s2    <= v_s1;
			w_s2    <= w_s1;
			sect_s2 <= sect_s1;
		end
	end

	// Stage 3: chroma times weight, and the grey part m.
	logic [XN_W-1:0]  xn_s3;
	logic [VAL_W-1:0] c_s3, m_s3;
	logic [2:0]       sect_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			xn_s3   <= XN_W'(c_s2) * XN_W'(w_s2);
			c_s3    <= c_s2;
			m_s3    <= v_s2 - c_s2;
			sect_s3 <= sect_s2;
		end
	end

	// Stage 4: divide by 60 through a reciprocal; exact over the whole range.
	logic [XP_W-1:0]  xp_s4;
	logic [VAL_W-1:0] c_s4, m_s4;
	logic [2:0]       sect_s4;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			xp_s4   <= XP_W'(xn_s3) * XP_W'(RECIP_V);
			c_s4    <= c_s3;
			m_s4    <= m_s3;
			sect_s4 <= sect_s3;
		end
	end

	// Stage 5: place the components and scale to eight bits.
	logic [VAL_W-1:0] x, pr, pg, pb;

	function automatic logic [7:0] to_chan(input logic [VAL_W-1:0] comp,
		input logic [VAL_W-1:0] m);
		logic [VAL_W-1:0] s;
		logic [VAL_W+7:0] t;
		logic [8:0]       c9;
		s  = comp + m;
		t  = {s, 8'b0} - (VAL_W+8)'(s);
		c9 = t[FRAC_BITS +: 9];
		return (c9 > 9'd255) ? 8'd255 : c9[7:0];
	endfunction

	always_comb begin
		x = xp_s4[K +: VAL_W];
		case (sect_s4)
			3'd0: begin pr = c_s4; pg = x;    pb = '0;   end
			3'd1: begin pr = x;    pg = c_s4; pb = '0;   end
			3'd2: begin pr = '0;   pg = c_s4; pb = x;    end
			3'd3: begin pr = '0;   pg = x;    pb = c_s4; end
			3'd4: begin pr = x;    pg = '0;   pb = c_s4; end
			default: begin pr = c_s4; pg = '0; pb = x;   end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			red   <= to_chan(pr, m_s4);
			green <= to_chan(pg, m_s4);
			blue  <= to_chan(pb, m_s4);
		end
	end

endmodule

>>> hw/rtl/hsv_colour_adjust_top.sv
// HSV colour adjustment, one 8-bit RGB pixel per request.
// pix_in takes a request when valid and ready are both high; pix_out
// presents the adjusted pixel under the same valid/ready rule.
// Hue, saturation and value offsets sit in three registers behind the
// APB port at byte addresses 0, 4 and 8; writes complete in the access
// cycle and pready is always high. Change them only while the pipeline
// is empty.
// The pipeline has one front stage for min/max and the hue numerator,
// FRAC_BITS + 1 divider stages that form hue and saturation one quotient
// bit each, and five stages for offsets, chroma, the divide by 60 and the
// output scaling. It takes one pixel per cycle unless pix_out stalls.
// Every stage holds its own valid bit, so when the receiver stalls the
// pipeline keeps filling its bubbles and only then drops ready on pix_in;
// nothing is lost or repeated.
// Reset clears all valid bits and the three offsets to zero.
`include "hsv_colour_adjust_top_defines.svh"

module hsv_colour_adjust_top #(
	parameter int FRAC_BITS = hsvca_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hsvca_in_if.sink                       pix_in,
	hsvca_out_if.source                    pix_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [hsvca_pkg::ADDR_W-1:0]   paddr,
	input  logic [hsvca_pkg::DATA_W-1:0]   pwdata,
	output logic [hsvca_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam int Q_W   = FRAC_BITS + 1;
	localparam int VAL_W = FRAC_BITS + 1;
	localparam int NUM_W = Q_W + 8;
	localparam int SB_W  = VAL_W + $bits(hsvca_pkg::div_flags_t);

	logic signed [hsvca_pkg::HUE_OFF_W-1:0] hue_off_q;
	logic signed [hsvca_pkg::SAT_OFF_W-1:0] sat_off_q;
	logic signed [hsvca_pkg::VAL_OFF_W-1:0] val_off_q;
	logic                                   wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_off_q <= '0;
			sat_off_q <= '0;
			val_off_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				hsvca_pkg::REG_HUE: hue_off_q <= pwdata[hsvca_pkg::HUE_OFF_W-1:0];
				hsvca_pkg::REG_SAT: sat_off_q <= pwdata[hsvca_pkg::SAT_OFF_W-1:0];
				hsvca_pkg::REG_VAL: val_off_q <= pwdata[hsvca_pkg::VAL_OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			hsvca_pkg::REG_HUE: prdata = hsvca_pkg::DATA_W'(unsigned'(hue_off_q));
			hsvca_pkg::REG_SAT: prdata = hsvca_pkg::DATA_W'(unsigned'(sat_off_q));
			hsvca_pkg::REG_VAL: prdata = hsvca_pkg::DATA_W'(unsigned'(val_off_q));
			default: prdata = '0;
		endcase
	end

	logic                  fr_valid, fr_ready;
	logic [NUM_W-1:0]      hnum, snum;
	logic [7:0]            hden, sden;
	logic [VAL_W-1:0]      fr_val, dv_val;
	hsvca_pkg::div_flags_t fr_flags, dv_flags;

	hsvca_front #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (NUM_W),
		.VAL_W     (VAL_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.red       (pix_in.red_in),
		.green     (pix_in.green_in),
		.blue      (pix_in.blue_in),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.hnum      (hnum),
		.hden      (hden),
		.snum      (snum),
		.sden      (sden),
		.val       (fr_val),
		.flags     (fr_flags)
	);

	logic           dv_valid, dv_ready;
	logic [Q_W-1:0] quo_h, quo_s;

	hsvca_div #(
		.Q_W   (Q_W),
		.SB_W  (SB_W),
		.NUM_W (NUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.num_a     (hnum),
		.den_a     (hden),
		.num_b     (snum),
		.den_b     (sden),
		.sb_in     ({fr_val, fr_flags}),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.quo_a     (quo_h),
		.quo_b     (quo_s),
		.sb_out    ({dv_val, dv_flags})
	);

	hsvca_back #(
		.FRAC_BITS (FRAC_BITS),
		.VAL_W     (VAL_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.hue_q     (quo_h),
		.sat_q     (quo_s),
		.val       (dv_val),
		.flags     (dv_flags),
		.hue_off   (hue_off_q),
		.sat_off   (sat_off_q),
		.val_off   (val_off_q),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.red       (pix_out.red_out),
		.green     (pix_out.green_out),
		.blue      (pix_out.blue_out)
	);

	`HSVCA_ASSERT_RST(a_reset_empty, !arst_n |-> !pix_out.valid, "output valid during reset")
	`HSVCA_ASSERT(a_empty_ready, !pix_out.valid |-> pix_in.ready, "empty output stage but input stalled")
	`HSVCA_ASSERT(a_hue_write, (wr_en && paddr[3:2] == hsvca_pkg::REG_HUE) |=> (hue_off_q == $past(pwdata[9:0])), "hue offset write lost")

endmodule
